// File: sv/ccv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccv_pkg
// Types, constants and the byte-wide CRC-16/CCITT-FALSE update shared by the
// container CRC validator.
// ----------------------------------------------------------------------------
package ccv_pkg;

	localparam int unsigned HDR_BASE  = 5;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY  = 16'h1021;

	typedef struct packed {
		logic        frame_ok;
		logic [15:0] computed_crc;
		logic [15:0] stored_crc;
	} ccv_result_t;

	// advance the CRC by one byte, MSB first
	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// File: sv/ccv_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ccv_frame
// Frame state: stored checksum capture, running CRC and saturating byte
// count. Produces the result for the word being absorbed.
// ----------------------------------------------------------------------------
module ccv_frame import ccv_pkg::*; #(
	parameter int unsigned PAD_BYTES = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        step,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output ccv_result_t result
);

	localparam int unsigned HEADER_SIZE = HDR_BASE + PAD_BYTES;
	localparam int unsigned CNT_W       = $clog2(HEADER_SIZE + 1);
	localparam logic [CNT_W-1:0] HDR_CNT = CNT_W'(HEADER_SIZE);

	logic [15:0]      crc_q;
	logic [15:0]      cap_q;
	logic [CNT_W-1:0] cnt_q;

	logic [15:0]      crc_d;
	logic [15:0]      cap_d;
	logic [CNT_W-1:0] cnt_d;

	always_comb begin
		crc_d = crc_q;
		cap_d = cap_q;
		if (cnt_q == '0) begin
			cap_d = {cap_q[15:8], data_byte};
		end else if (cnt_q == CNT_W'(1)) begin
			cap_d = {data_byte, cap_q[7:0]};
		end else begin
			crc_d = crc_feed(crc_q, data_byte);
		end
		cnt_d = (cnt_q < HDR_CNT) ? cnt_q + CNT_W'(1) : cnt_q;
	end

	assign result.frame_ok     = (cnt_d >= HDR_CNT) && (crc_d == cap_d);
	assign result.computed_crc = crc_d;
	assign result.stored_crc   = cap_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			cap_q <= '0;
			cnt_q <= '0;
		end else if (step) begin
			if (last_byte) begin
				crc_q <= CRC_INIT;
				cap_q <= '0;
				cnt_q <= '0;
			end else begin
				crc_q <= crc_d;
				cap_q <= cap_d;
				cnt_q <= cnt_d;
			end
		end
	end

endmodule

// File: sv/container_crc16_validator_top.sv
`timescale 1ns / 1ps
// An accepted last word is held in byte_s1/last_s1, then its result is registered in res_q.
// Throughput: one word per cycle; a word that is not last is absorbed even while
// a result waits, and a last word moves on as soon as the result register is free.
// Reset: arst_n clears the frame state (CRC to 0xFFFF, checksum and count to zero)
// and all valid flags; the frame state also returns to reset after every last word.
// ----------------------------------------------------------------------------
// container_crc16_validator_top
// Container frame checker: captures the little-endian stored CRC, runs
// CRC-16/CCITT-FALSE over the remaining bytes and reports the comparison.
// ----------------------------------------------------------------------------
module container_crc16_validator_top import ccv_pkg::*; #(
	parameter int unsigned PAD_BYTES = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        frame_ok,
	output logic [15:0] computed_crc,
	output logic [15:0] stored_crc
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        out_free;
	logic        move_s1;
	ccv_result_t res;
	ccv_result_t res_q;
	logic        out_valid_q;

	assign out_free = !out_valid_q || !out_stall;
	assign move_s1  = valid_s1 && (!last_s1 || out_free);
	assign in_stall = valid_s1 && !move_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	ccv_frame #(
		.PAD_BYTES(PAD_BYTES)
	) u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (move_s1),
		.data_byte(byte_s1),
		.last_byte(last_s1),
		.result   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= move_s1 && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1 && last_s1) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign frame_ok     = res_q.frame_ok;
	assign computed_crc = res_q.computed_crc;
	assign stored_crc   = res_q.stored_crc;

	a_stall_only_last: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && last_s1 && out_valid_q && out_stall))
		else $error("input stalled without a blocked last word");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(res_q)))
		else $error("waiting result word overwritten or dropped");

	a_ok_match: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_q.frame_ok) |-> (res_q.computed_crc == res_q.stored_crc))
		else $error("frame_ok set with mismatching CRCs");

endmodule

// File: verif/tb_container_crc16_validator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_container_crc16_validator_top
// Self-checking bench for the container CRC validator. Frames are built with
// a correct or corrupted little-endian checksum. Each accepted word runs
// through a local CRC-16/CCITT-FALSE predictor, and every result word is
// checked field by field against the oldest predicted verdict. Covers
// directed edge frames, back-to-back traffic, a long output hold-off and
// random frames with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_container_crc16_validator_top;
	import ccv_pkg::*;

	localparam int unsigned PAD_BYTES = 3;
	localparam int unsigned HDR_LEN   = HDR_BASE + PAD_BYTES;

	typedef logic [7:0] byte_q_t[$];

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        last_byte = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        frame_ok;
	logic [15:0] computed_crc;
	logic [15:0] stored_crc;

	// predictor state
	logic [15:0] frame_crc = CRC_INIT;
	logic [15:0] frame_cksum = 16'h0000;
	logic [5:0]  frame_len = 6'd0;

	ccv_result_t pending_verdicts[$];

	bit          tx_gaps_on = 1'b1;
	bit          rx_gaps_on = 1'b1;
	logic        hold_results = 1'b0;
	int unsigned mismatch_count = 0;
	int unsigned words_sent = 0;
	int unsigned frames_sent = 0;
	int unsigned frames_passing = 0;
	int unsigned frames_short = 0;
	int unsigned results_checked = 0;

	container_crc16_validator_top #(
		.PAD_BYTES(PAD_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.frame_ok(frame_ok),
		.computed_crc(computed_crc),
		.stored_crc(stored_crc)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("Timeout: %0d verdicts still outstanding", pending_verdicts.size());
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [15:0] crc_ccitt_step(input logic [15:0] acc, input logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb  = acc[15] ^ b[i];
			acc = {acc[14:0], 1'b0};
			if (fb) begin
				acc = acc ^ CRC_POLY;
			end
		end
		return acc;
	endfunction

	// advance the frame state by one word; queue a verdict on the last one
	function automatic void predict_word(input logic [7:0] b, input logic lst);
		ccv_result_t v;
		if (frame_len == 6'd0) begin
			frame_cksum[7:0] = b;
		end else if (frame_len == 6'd1) begin
			frame_cksum[15:8] = b;
		end else begin
			frame_crc = crc_ccitt_step(frame_crc, b);
		end
		if (frame_len < HDR_LEN) begin
			frame_len = frame_len + 6'd1;
		end
		if (lst) begin
			v.frame_ok     = (frame_len >= HDR_LEN) && (frame_crc == frame_cksum);
			v.computed_crc = frame_crc;
			v.stored_crc   = frame_cksum;
			pending_verdicts.push_back(v);
			if (v.frame_ok) begin
				frames_passing++;
			end
			if (frame_len < HDR_LEN) begin
				frames_short++;
			end
			frames_sent++;
			frame_crc   = CRC_INIT;
			frame_cksum = 16'h0000;
			frame_len   = 6'd0;
		end
	endfunction

	function automatic byte_q_t build_frame(input int unsigned n, input bit corrupt);
		byte_q_t f;
		logic [15:0] c;
		int unsigned pos;
		c = CRC_INIT;
		for (int i = 0; i < n; i++) begin
			f.push_back(8'($urandom_range(255)));
		end
		for (int i = 2; i < n; i++) begin
			c = crc_ccitt_step(c, f[i]);
		end
		if (n > 0) begin
			f[0] = c[7:0];
		end
		if (n > 1) begin
			f[1] = c[15:8];
		end
		if (corrupt && n > 0) begin
			pos = $urandom_range(n - 1);
			f[pos] = f[pos] ^ (8'h01 << $urandom_range(7));
		end
		return f;
	endfunction

	task automatic flag_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// offer one word and hold it until accepted; called just after a rising edge
	task automatic send_word(input logic [7:0] b, input logic lst);
		while (tx_gaps_on && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= lst;
		do begin
			@(posedge clk);
		end while (in_stall);
		predict_word(b, lst);
		words_sent++;
	endtask

	task automatic send_frame(input byte_q_t f);
		for (int i = 0; i < f.size(); i++) begin
			send_word(f[i], i == f.size() - 1);
		end
	endtask

	always @(posedge clk) begin : result_check
		ccv_result_t want;
		if (out_valid && !out_stall) begin
			results_checked++;
			if (pending_verdicts.size() == 0) begin
				flag_mismatch($sformatf("unexpected result ok=%0b crc=%04h stored=%04h",
					frame_ok, computed_crc, stored_crc));
			end else begin
				want = pending_verdicts.pop_front();
				if (frame_ok !== want.frame_ok) begin
					flag_mismatch($sformatf("frame_ok %0b, want %0b", frame_ok, want.frame_ok));
				end
				if (computed_crc !== want.computed_crc) begin
					flag_mismatch($sformatf("computed_crc %04h, want %04h",
						computed_crc, want.computed_crc));
				end
				if (stored_crc !== want.stored_crc) begin
					flag_mismatch($sformatf("stored_crc %04h, want %04h",
						stored_crc, want.stored_crc));
				end
			end
		end
		out_stall <= hold_results || (rx_gaps_on && $urandom_range(99) < 31);
	end

	task automatic test_edge_frames();
		send_word(8'hFF, 1'b1);
		send_word(8'h00, 1'b0);
		send_word(8'hFF, 1'b1);
		// matching checksum but one byte too short
		send_frame(build_frame(HDR_LEN - 1, 1'b0));
		send_frame(build_frame(HDR_LEN, 1'b0));
		send_frame(build_frame(HDR_LEN, 1'b1));
	endtask

	task automatic test_back_to_back(input int unsigned n_words);
		int unsigned stop_at;
		stop_at = words_sent + n_words;
		tx_gaps_on = 1'b0;
		rx_gaps_on = 1'b0;
		while (words_sent < stop_at) begin
			send_frame(build_frame($urandom_range(HDR_LEN + 12, 1), $urandom_range(3) == 0));
		end
		tx_gaps_on = 1'b1;
		rx_gaps_on = 1'b1;
	endtask

	// hold the output for a long stretch while short frames keep arriving
	task automatic test_output_hold_off();
		tx_gaps_on = 1'b0;
		fork
			begin
				hold_results <= 1'b1;
				repeat (150) @(posedge clk);
				hold_results <= 1'b0;
			end
			begin
				for (int i = 0; i < 30; i++) begin
					send_frame(build_frame($urandom_range(3, 1), 1'b0));
				end
			end
		join
		tx_gaps_on = 1'b1;
	endtask

	task automatic test_random_frames(input int unsigned n_words);
		int unsigned stop_at;
		int unsigned pick;
		int unsigned n;
		stop_at = words_sent + n_words;
		while (words_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				n = $urandom_range(HDR_LEN - 1, 1);
			end else if (pick < 15) begin
				n = $urandom_range(70, 40);
			end else begin
				n = $urandom_range(HDR_LEN + 24, HDR_LEN);
			end
			send_frame(build_frame(n, $urandom_range(99) < 20));
		end
	endtask

	initial begin
		int unsigned drain;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_edge_frames();
		test_back_to_back(200);
		test_output_hold_off();
		test_random_frames(800);
		in_valid  <= 1'b0;
		last_byte <= 1'b0;
		drain = 0;
		while (pending_verdicts.size() != 0 && drain < 2000) begin
			@(posedge clk);
			drain++;
		end
		repeat (10) @(posedge clk);
		if (pending_verdicts.size() != 0) begin
			flag_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
		end
		$display("Sent %0d words in %0d frames: %0d valid, %0d short, %0d results checked.",
			words_sent, frames_sent, frames_passing, frames_short, results_checked);
		$display("Traffic mixed random idling, back-to-back runs and a long output %s%0d.",
			"hold-off; mismatches: ", mismatch_count);
		if (mismatch_count == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
